/* design/kth_of_two_sorted_arrays_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the k-th of two sorted arrays unit
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef KTH_OF_TWO_SORTED_ARRAYS_UNIT_ASSERT_SVH
`define KTH_OF_TWO_SORTED_ARRAYS_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define KTSA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high
`define KTSA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ktsa_pkg.sv */
// ----------------------------------------------------------------------------
// ktsa_pkg
// Sizes, request codes and types shared by the k-th of two sorted arrays unit.
// ----------------------------------------------------------------------------
package ktsa_pkg;

  // Entries in each of the two element stores
  localparam int ARRAY_DEPTH = 1024;

  localparam int DATA_W = 32;
  localparam int REQ_W  = 2;
  localparam int RANK_W = 12;
  localparam int IDX_W  = $clog2(ARRAY_DEPTH);
  localparam int CNT_W  = $clog2(ARRAY_DEPTH + 1);
  // Signed search width: holds rank, count sum, and low/high out of range by one
  localparam int SRCH_W = ((RANK_W > CNT_W + 1) ? RANK_W : (CNT_W + 1)) + 1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  typedef logic [DATA_W-1:0]        data_t;
  typedef logic [IDX_W-1:0]         addr_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic signed [SRCH_W-1:0] srch_t;

  // Write and read addresses of one element store
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    data_t wr_data;
    addr_t rd_addr0;
    addr_t rd_addr1;
  } mem_req_t;

endpackage

/* design/ktsa_mem.sv */
// ----------------------------------------------------------------------------
// ktsa_mem
// Element store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ktsa_mem (
  input  logic              clk,
  input  ktsa_pkg::mem_req_t req,
  output ktsa_pkg::data_t   rd_data0,
  output ktsa_pkg::data_t   rd_data1
);

  ktsa_pkg::data_t mem [ktsa_pkg::ARRAY_DEPTH];

  // Write on request
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read both ports into registered outputs
  always_ff @(posedge clk) begin
    rd_data0 <= mem[req.rd_addr0];
    rd_data1 <= mem[req.rd_addr1];
  end

endmodule

/* design/kth_of_two_sorted_arrays_unit.sv */
// ----------------------------------------------------------------------------
// kth_of_two_sorted_arrays_unit
// Loads two ascending arrays and returns the k-th smallest of their union.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low.
//   req_type selects: append element_value to array A, append it to array B,
//   or query rank (1-based). Appends give no result;
//   an append to a full array is dropped. Request code 3 is ignored.
//   A query gives exactly one result: done is high for one cycle with
//   kth_value and found. The receiver cannot stall; kth_value and found
//   hold until the next result, but done marks them for that one cycle only.
//   A query with rank zero or beyond the element total answers in the next
//   cycle with found low. Otherwise busy stays high during a binary search
//   of the split of A; each probe addresses and reads both stores, then
//   compares, ending when a split is found or the window runs empty, after
//   at most floor(log2(depth+1))+1 probes (11 at depth 1024). done comes in
//   the cycle busy drops. Either way the query empties both arrays.
//   Reset (rst, synchronous) empties both arrays and aborts any search;
//   the stores themselves are not cleared.
// ----------------------------------------------------------------------------
module kth_of_two_sorted_arrays_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type,
  input  logic signed [31:0]  element_value,
  input  logic [11:0]         rank,
  output logic                done,
  output logic signed [31:0]  kth_value,
  output logic                found
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_EVAL
  } state_t;

  localparam ktsa_pkg::count_t DEPTH_CNT = ktsa_pkg::CNT_W'(ktsa_pkg::ARRAY_DEPTH);

  state_t           state;
  ktsa_pkg::count_t count_a;
  ktsa_pkg::count_t count_b;
  ktsa_pkg::srch_t  n_len;
  ktsa_pkg::srch_t  m_len;
  ktsa_pkg::srch_t  k_rank;
  ktsa_pkg::srch_t  low;
  ktsa_pkg::srch_t  high;
  ktsa_pkg::srch_t  i_split;
  logic             al_ok;
  logic             ar_ok;
  logic             bl_ok;
  logic             br_ok;

  ktsa_pkg::mem_req_t req_a;
  ktsa_pkg::mem_req_t req_b;
  ktsa_pkg::data_t    a_left;
  ktsa_pkg::data_t    a_right;
  ktsa_pkg::data_t    b_left;
  ktsa_pkg::data_t    b_right;

  logic             accept;
  ktsa_pkg::srch_t  rank_x;
  ktsa_pkg::srch_t  cnt_a_x;
  ktsa_pkg::srch_t  cnt_b_x;
  ktsa_pkg::srch_t  total;
  logic             rank_ok;
  ktsa_pkg::srch_t  low_init;
  ktsa_pkg::srch_t  high_init;
  ktsa_pkg::srch_t  mid;
  ktsa_pkg::srch_t  mid_m1;
  ktsa_pkg::srch_t  j_mid;
  ktsa_pkg::srch_t  j_m1;
  logic             a_over;
  logic             b_over;
  logic signed [31:0] pick;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Extend rank and counts into the search width
  assign rank_x  = {{(ktsa_pkg::SRCH_W - ktsa_pkg::RANK_W){1'b0}}, rank};
  assign cnt_a_x = {{(ktsa_pkg::SRCH_W - ktsa_pkg::CNT_W){1'b0}}, count_a};
  assign cnt_b_x = {{(ktsa_pkg::SRCH_W - ktsa_pkg::CNT_W){1'b0}}, count_b};
  assign total   = cnt_a_x + cnt_b_x;
  assign rank_ok = (rank_x != '0) && (rank_x <= total);

  // Initial search window on A
  assign low_init  = (rank_x > cnt_b_x) ? (rank_x - cnt_b_x) : '0;
  assign high_init = (rank_x < cnt_a_x) ? rank_x : cnt_a_x;

  // Split probe
  assign mid    = low + ((high - low) >>> 1);
  assign mid_m1 = mid - ktsa_pkg::srch_t'(1);
  assign j_mid  = k_rank - mid;
  assign j_m1   = j_mid - ktsa_pkg::srch_t'(1);

  // Store ports: appends write, probes read both neighbors
  always_comb begin
    req_a.wr_en    = accept && (req_type == ktsa_pkg::REQ_LOAD_A) && (count_a != DEPTH_CNT);
    req_a.wr_addr  = count_a[ktsa_pkg::IDX_W-1:0];
    req_a.wr_data  = element_value;
    req_a.rd_addr0 = mid_m1[ktsa_pkg::IDX_W-1:0];
    req_a.rd_addr1 = mid[ktsa_pkg::IDX_W-1:0];
    req_b.wr_en    = accept && (req_type == ktsa_pkg::REQ_LOAD_B) && (count_b != DEPTH_CNT);
    req_b.wr_addr  = count_b[ktsa_pkg::IDX_W-1:0];
    req_b.wr_data  = element_value;
    req_b.rd_addr0 = j_m1[ktsa_pkg::IDX_W-1:0];
    req_b.rd_addr1 = j_mid[ktsa_pkg::IDX_W-1:0];
  end

  ktsa_mem u_mem_a (
    .clk      (clk),
    .req      (req_a),
    .rd_data0 (a_left),
    .rd_data1 (a_right)
  );

  ktsa_mem u_mem_b (
    .clk      (clk),
    .req      (req_b),
    .rd_data0 (b_left),
    .rd_data1 (b_right)
  );

  // Left-max / right-min test on the read data
  assign a_over = al_ok && br_ok && ($signed(a_left) > $signed(b_right));
  assign b_over = bl_ok && ar_ok && ($signed(b_left) > $signed(a_right));

  // Larger of the existing left neighbors
  always_comb begin
    priority if (al_ok && bl_ok) begin
      pick = ($signed(a_left) >= $signed(b_left)) ? $signed(a_left) : $signed(b_left);
    end else if (al_ok) begin
      pick = $signed(a_left);
    end else if (bl_ok) begin
      pick = $signed(b_left);
    end else begin
      pick = '0;
    end
  end

  // Sequencer: appends, query setup, probe loop, result
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count_a <= '0;
      count_b <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (req_type)
              ktsa_pkg::REQ_LOAD_A: begin
                if (count_a != DEPTH_CNT) begin
                  count_a <= count_a + ktsa_pkg::count_t'(1);
                end
              end
              ktsa_pkg::REQ_LOAD_B: begin
                if (count_b != DEPTH_CNT) begin
                  count_b <= count_b + ktsa_pkg::count_t'(1);
                end
              end
              ktsa_pkg::REQ_QUERY: begin
                n_len   <= cnt_a_x;
                m_len   <= cnt_b_x;
                k_rank  <= rank_x;
                low     <= low_init;
                high    <= high_init;
                count_a <= '0;
                count_b <= '0;
                if (rank_ok) begin
                  state <= S_CALC;
                end else begin
                  done      <= 1'b1;
                  found     <= 1'b0;
                  kth_value <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CALC: begin
          if (low > high) begin
            done      <= 1'b1;
            found     <= 1'b0;
            kth_value <= '0;
            state     <= S_IDLE;
          end else begin
            i_split <= mid;
            al_ok   <= (mid > ktsa_pkg::srch_t'(0));
            ar_ok   <= (mid < n_len);
            bl_ok   <= (j_mid > ktsa_pkg::srch_t'(0));
            br_ok   <= (j_mid < m_len);
            state   <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!a_over && !b_over) begin
            done      <= 1'b1;
            found     <= al_ok || bl_ok;
            kth_value <= pick;
            state     <= S_IDLE;
          end else if (a_over) begin
            high  <= i_split - ktsa_pkg::srch_t'(1);
            state <= S_CALC;
          end else begin
            low   <= i_split + ktsa_pkg::srch_t'(1);
            state <= S_CALC;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/ktsa_checker.sv */
// ----------------------------------------------------------------------------
// ktsa_checker
// Port-level checks of the k-th of two sorted arrays unit, bound to the top.
// ----------------------------------------------------------------------------
`include "kth_of_two_sorted_arrays_unit_assert.svh"

module ktsa_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         req_type,
  input logic [11:0]        rank,
  input logic               done,
  input logic signed [31:0] kth_value,
  input logic               found
);

  logic accept;
  assign accept = start && !busy;

  // A miss always carries a zero value
  `KTSA_ASSERT_NOW(a_miss_zero, clk, rst, done && !found, kth_value == 0, "miss with nonzero value")

  // A result frees the unit in the same cycle
  `KTSA_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result shown while busy")

  // Only a query starts a search
  `KTSA_ASSERT_NOW(a_busy_query, clk, rst, $rose(busy), $past(accept && (req_type == ktsa_pkg::REQ_QUERY)), "busy without query")

  // Rank zero answers at once with a miss
  `KTSA_ASSERT_NEXT(a_rank_zero, clk, rst, accept && (req_type == ktsa_pkg::REQ_QUERY) && (rank == 0), done && !found, "rank zero not answered")

  // Appends and unused codes give no result
  `KTSA_ASSERT_NEXT(a_load_quiet, clk, rst, accept && (req_type != ktsa_pkg::REQ_QUERY), !done, "result after append")

endmodule

bind kth_of_two_sorted_arrays_unit ktsa_checker u_ktsa_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .req_type  (req_type),
  .rank      (rank),
  .done      (done),
  .kth_value (kth_value),
  .found     (found)
);
